// ===== rtl/core/qtar_pkg.sv =====
// Shared constants and types for the quantized tensor axis reduction block.
package qtar_pkg;

  // Configuration register indexes (byte address is four times the index).
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_DIM_N = 3'd0;
  localparam reg_idx_t REG_DIM_H = 3'd1;
  localparam reg_idx_t REG_DIM_W = 3'd2;
  localparam reg_idx_t REG_DIM_C = 3'd3;
  localparam reg_idx_t REG_AXIS_MASK = 3'd4;
  localparam reg_idx_t REG_ZERO_IN = 3'd5;
  localparam reg_idx_t REG_ZERO_OUT = 3'd6;
  localparam reg_idx_t REG_REQUANT_MULT = 3'd7;

  // Register field widths.
  localparam int DIM_CFG_W = 13;
  localparam int MASK_W = 4;
  localparam int BYTE_W = 8;
  localparam int MULT_W = 32;

  // Accumulator and requantization datapath widths.
  localparam int ACC_W = 40;
  localparam int HALF_W = 20;
  localparam int DIFF_W = 9;
  localparam int PROD_W = HALF_W + MULT_W;
  localparam int TOT_W = PROD_W + HALF_W + 1;
  localparam int Q_W = 10;
  localparam logic [Q_W-1:0] QCAP = 10'd512;
  localparam int V_W = 11;

  // Geometry sequencer: four stride jobs followed by four offset jobs.
  localparam int JOB_W = 3;
  localparam logic [JOB_W-1:0] LAST_JOB = 3'd7;

  // Result queue.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PW = 3;
  localparam int FIFO_CW = 4;
  localparam int CREDIT_W = 5;

endpackage

// ===== rtl/core/quantized_tensor_axis_reduce.sv =====
// Streaming reduction of a quantized NHWC uint8 tensor over selected axes, with requantization.
//
// Elements are accepted one per cycle in NHWC order while results are being taken; a result
// leaves the block through the registered stages a, b, c, d and e after the element that
// finishes its accumulator, then through an eight-entry result queue, and in_ready drops
// when that queue and the results still in the pipeline would fill it. The accumulators live
// in one ACC_DEPTH x 40 memory with a registered read; each element costs one read and one
// write of that memory, and a write followed at once by a read of the same entry is forwarded.
// The memory is never cleared: the first element of each accumulator overwrites it. The output
// address is kept as one offset per axis, modulo ACC_DEPTH. After a write to a dimension
// register or to axis_mask, a shared bit-serial modular multiplier rebuilds the strides and
// offsets in eight jobs of DW bits (DW is the bit width of MAX_DIM, 13 for the default), and
// in_ready stays low until it is done. Write the registers only while no element is in flight.
module quantized_tensor_axis_reduce #(
  parameter int MAX_DIM = 4096,
  parameter int ACC_DEPTH = 4096,
  parameter int FRAC_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  // Element stream.
  input  logic in_valid,
  output logic in_ready,
  input  logic [qtar_pkg::BYTE_W-1:0] element_value,
  // Result stream.
  output logic out_valid,
  input  logic out_ready,
  output logic [qtar_pkg::BYTE_W-1:0] result_value,
  output logic [((ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1)-1:0] out_index,
  output logic saturated,
  output logic last_result,
  // Register port.
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [qtar_pkg::PADDR_W-1:0] paddr,
  input  logic [qtar_pkg::PDATA_W-1:0] pwdata,
  output logic [qtar_pkg::PDATA_W-1:0] prdata,
  output logic pready
);

  localparam int AW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
  localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW = ($clog2(MAX_DIM + 1) > 2) ? $clog2(MAX_DIM + 1) : 2;
  localparam int BW = $clog2(DW);
  localparam logic [AW-1:0] ONE_MOD = (ACC_DEPTH > 1) ? AW'(1) : AW'(0);

  // Sum of two residues modulo ACC_DEPTH.
  function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] x, input logic [AW-1:0] y);
    logic [AW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= (AW+1)'(ACC_DEPTH)) s = s - (AW+1)'(ACC_DEPTH);
    return s[AW-1:0];
  endfunction

  // A size of zero acts as one, a size above MAX_DIM acts as MAX_DIM.
  function automatic logic [DW-1:0] eff_dim(input logic [qtar_pkg::DIM_CFG_W-1:0] d);
    logic [31:0] dx;
    logic [DW-1:0] e;
    dx = 32'(d);
    if (dx == 32'd0) e = DW'(1);
    else if (dx > 32'(MAX_DIM)) e = DW'(MAX_DIM);
    else e = DW'(dx);
    return e;
  endfunction

  // ---------------------------------------------------------------- registers
  logic [qtar_pkg::DIM_CFG_W-1:0] dim_n, dim_h, dim_w, dim_c;
  logic [qtar_pkg::MASK_W-1:0] axis_mask;
  logic [qtar_pkg::BYTE_W-1:0] zero_in, zero_out;
  logic [qtar_pkg::MULT_W-1:0] requant_mult;

  logic cfg_wr;
  qtar_pkg::reg_idx_t cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[qtar_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_n <= qtar_pkg::DIM_CFG_W'(1);
      dim_h <= qtar_pkg::DIM_CFG_W'(1);
      dim_w <= qtar_pkg::DIM_CFG_W'(1);
      dim_c <= qtar_pkg::DIM_CFG_W'(1);
      axis_mask <= '1;
      zero_in <= '0;
      zero_out <= '0;
      requant_mult <= qtar_pkg::MULT_W'(32'h0100_0000);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        qtar_pkg::REG_DIM_N: dim_n <= pwdata[qtar_pkg::DIM_CFG_W-1:0];
        qtar_pkg::REG_DIM_H: dim_h <= pwdata[qtar_pkg::DIM_CFG_W-1:0];
        qtar_pkg::REG_DIM_W: dim_w <= pwdata[qtar_pkg::DIM_CFG_W-1:0];
        qtar_pkg::REG_DIM_C: dim_c <= pwdata[qtar_pkg::DIM_CFG_W-1:0];
        qtar_pkg::REG_AXIS_MASK: axis_mask <= pwdata[qtar_pkg::MASK_W-1:0];
        qtar_pkg::REG_ZERO_IN: zero_in <= pwdata[qtar_pkg::BYTE_W-1:0];
        qtar_pkg::REG_ZERO_OUT: zero_out <= pwdata[qtar_pkg::BYTE_W-1:0];
        qtar_pkg::REG_REQUANT_MULT: requant_mult <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      qtar_pkg::REG_DIM_N: prdata = qtar_pkg::PDATA_W'(dim_n);
      qtar_pkg::REG_DIM_H: prdata = qtar_pkg::PDATA_W'(dim_h);
      qtar_pkg::REG_DIM_W: prdata = qtar_pkg::PDATA_W'(dim_w);
      qtar_pkg::REG_DIM_C: prdata = qtar_pkg::PDATA_W'(dim_c);
      qtar_pkg::REG_AXIS_MASK: prdata = qtar_pkg::PDATA_W'(axis_mask);
      qtar_pkg::REG_ZERO_IN: prdata = qtar_pkg::PDATA_W'(zero_in);
      qtar_pkg::REG_ZERO_OUT: prdata = qtar_pkg::PDATA_W'(zero_out);
      qtar_pkg::REG_REQUANT_MULT: prdata = requant_mult;
    endcase
  end

  // ---------------------------------------------------------------- geometry
  logic [DW-1:0] eff [4];
  logic [CW-1:0] crd [4];
  logic [CW-1:0] crd_next [4];
  logic [AW-1:0] term [4];
  logic [AW-1:0] term_next [4];
  logic [AW-1:0] stride [4];
  logic [3:0] at_max;
  logic first, finish, at_end, adv_carry;
  logic [AW-1:0] s01, s23, addr_comb;

  assign eff[0] = eff_dim(dim_n);
  assign eff[1] = eff_dim(dim_h);
  assign eff[2] = eff_dim(dim_w);
  assign eff[3] = eff_dim(dim_c);

  // A coordinate at or beyond its last position counts as at its maximum.
  always_comb begin
    first = 1'b1;
    finish = 1'b1;
    at_end = 1'b1;
    for (int k = 0; k < 4; k++) begin
      at_max[k] = (32'(crd[k]) + 32'd1) >= 32'(eff[k]);
      if (!at_max[k]) at_end = 1'b0;
      if (axis_mask[k]) begin
        if (crd[k] != '0) first = 1'b0;
        if (!at_max[k]) finish = 1'b0;
      end
    end
    adv_carry = 1'b1;
    for (int k = 3; k >= 0; k--) begin
      crd_next[k] = crd[k];
      term_next[k] = term[k];
      if (adv_carry) begin
        if (at_max[k]) begin
          crd_next[k] = '0;
          term_next[k] = '0;
        end else begin
          crd_next[k] = crd[k] + CW'(1);
          term_next[k] = mod_add(term[k], stride[k]);
          adv_carry = 1'b0;
        end
      end
    end
  end

  // Offsets of reduced axes are always zero, so the address is the sum of all four.
  assign s01 = mod_add(term[0], term[1]);
  assign s23 = mod_add(term[2], term[3]);
  assign addr_comb = mod_add(s01, s23);

  // Bit-serial modular multiplier that rebuilds strides and offsets after a geometry write.
  logic busy;
  logic [qtar_pkg::JOB_W-1:0] job;
  logic [BW-1:0] bcnt;
  logic [AW-1:0] seq_r, prod;
  logic [1:0] job_k;
  logic [AW-1:0] seq_a, r2, r_step;
  logic [DW-1:0] seq_m;
  logic in_accept;

  assign job_k = job[2] ? job[1:0] : ~job[1:0];
  assign seq_a = job[2] ? stride[job_k] : prod;
  assign seq_m = job[2] ? DW'(crd[job_k]) : (axis_mask[job_k] ? DW'(1) : eff[job_k]);
  assign r2 = mod_add(seq_r, seq_r);
  assign r_step = seq_m[bcnt] ? mod_add(r2, seq_a) : r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      job <= '0;
      bcnt <= '0;
      seq_r <= '0;
      prod <= '0;
      for (int k = 0; k < 4; k++) begin
        crd[k] <= '0;
        term[k] <= '0;
        stride[k] <= '0;
      end
    end else if (cfg_wr && (cfg_idx <= qtar_pkg::REG_AXIS_MASK)) begin
      busy <= 1'b1;
      job <= '0;
      bcnt <= BW'(DW - 1);
      seq_r <= '0;
      prod <= ONE_MOD;
    end else if (busy) begin
      if (bcnt == '0) begin
        seq_r <= '0;
        bcnt <= BW'(DW - 1);
        if (job[2]) begin
          term[job_k] <= r_step;
        end else begin
          stride[job_k] <= axis_mask[job_k] ? '0 : prod;
          prod <= r_step;
        end
        job <= job + qtar_pkg::JOB_W'(1);
        if (job == qtar_pkg::LAST_JOB) busy <= 1'b0;
      end else begin
        seq_r <= r_step;
        bcnt <= bcnt - BW'(1);
      end
    end else if (in_accept) begin
      for (int k = 0; k < 4; k++) begin
        crd[k] <= crd_next[k];
        term[k] <= term_next[k];
      end
    end
  end

  // ---------------------------------------------------------------- accumulate
  logic a_vld, a_first, a_fin, a_last;
  logic [AW-1:0] a_addr;
  logic signed [qtar_pkg::DIFF_W-1:0] a_diff;
  logic [qtar_pkg::ACC_W-1:0] acc_mem [ACC_DEPTH];
  logic [qtar_pkg::ACC_W-1:0] rdata, fwd_data, old_acc, diff40, acc_sum;
  logic fwd_hit;

  always_ff @(posedge clk) begin
    if (a_vld) acc_mem[a_addr] <= acc_sum;
    rdata <= acc_mem[addr_comb];
  end

  // The entry written this cycle reads stale if the next element hits it, so bypass it.
  always_ff @(posedge clk) begin
    if (rst) fwd_hit <= 1'b0;
    else fwd_hit <= a_vld && (a_addr == addr_comb);
    fwd_data <= acc_sum;
  end

  assign diff40 = qtar_pkg::ACC_W'(a_diff);
  assign old_acc = fwd_hit ? fwd_data : rdata;
  assign acc_sum = a_first ? diff40 : (old_acc + diff40);

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else a_vld <= in_accept;
    a_addr <= addr_comb;
    a_first <= first;
    a_fin <= finish;
    a_last <= at_end;
    a_diff <= $signed({1'b0, element_value}) - $signed({1'b0, zero_in});
  end

  // ---------------------------------------------------------------- requantize
  logic b_vld, c_vld, d_vld, e_vld;
  logic b_last, c_last, d_last, e_last;
  logic [AW-1:0] b_addr, c_addr, d_addr, e_addr;
  logic [qtar_pkg::ACC_W-1:0] b_acc, c_mag, b_mag;
  logic b_neg, c_neg, d_neg, e_neg;
  logic [qtar_pkg::PROD_W-1:0] d_phi, d_plo;
  logic [qtar_pkg::TOT_W-1:0] d_total, d_qf;
  logic [qtar_pkg::Q_W-1:0] d_q, e_q;
  logic signed [qtar_pkg::V_W-1:0] e_v;
  logic [qtar_pkg::BYTE_W-1:0] e_res;
  logic e_sat;

  assign b_neg = b_acc[qtar_pkg::ACC_W-1];
  assign b_mag = b_neg ? (~b_acc + qtar_pkg::ACC_W'(1)) : b_acc;

  // Magnitude times multiplier plus half an LSB, then truncated; anything past 512 clamps.
  assign d_total = (qtar_pkg::TOT_W'(d_phi) << qtar_pkg::HALF_W) + qtar_pkg::TOT_W'(d_plo)
                 + (qtar_pkg::TOT_W'(1) << (FRAC_BITS - 1));
  assign d_qf = d_total >> FRAC_BITS;
  assign d_q = (d_qf > qtar_pkg::TOT_W'(qtar_pkg::QCAP)) ? qtar_pkg::QCAP
             : d_qf[qtar_pkg::Q_W-1:0];

  always_comb begin
    if (e_neg) e_v = $signed({3'b000, zero_out}) - $signed({1'b0, e_q});
    else e_v = $signed({3'b000, zero_out}) + $signed({1'b0, e_q});
    if (e_v < 0) begin
      e_res = '0;
      e_sat = 1'b1;
    end else if (e_v > 255) begin
      e_res = '1;
      e_sat = 1'b1;
    end else begin
      e_res = e_v[qtar_pkg::BYTE_W-1:0];
      e_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
    end else begin
      b_vld <= a_vld && a_fin;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
    end
    b_acc <= acc_sum;
    b_addr <= a_addr;
    b_last <= a_last;
    c_mag <= b_mag;
    c_neg <= b_neg;
    c_addr <= b_addr;
    c_last <= b_last;
    d_phi <= c_mag[qtar_pkg::ACC_W-1:qtar_pkg::HALF_W] * requant_mult;
    d_plo <= c_mag[qtar_pkg::HALF_W-1:0] * requant_mult;
    d_neg <= c_neg;
    d_addr <= c_addr;
    d_last <= c_last;
    e_q <= d_q;
    e_neg <= d_neg;
    e_addr <= d_addr;
    e_last <= d_last;
  end

  // ---------------------------------------------------------------- result queue
  logic [qtar_pkg::BYTE_W-1:0] f_val [qtar_pkg::FIFO_DEPTH];
  logic [AW-1:0] f_idx [qtar_pkg::FIFO_DEPTH];
  logic f_sat [qtar_pkg::FIFO_DEPTH];
  logic f_last [qtar_pkg::FIFO_DEPTH];
  logic [qtar_pkg::FIFO_PW-1:0] wptr, rptr;
  logic [qtar_pkg::FIFO_CW-1:0] count;
  logic [qtar_pkg::FIFO_CW-1:0] inflight;
  logic out_pop;

  assign inflight = qtar_pkg::FIFO_CW'(a_vld && a_fin) + qtar_pkg::FIFO_CW'(b_vld)
                  + qtar_pkg::FIFO_CW'(c_vld) + qtar_pkg::FIFO_CW'(d_vld)
                  + qtar_pkg::FIFO_CW'(e_vld);

  // Every result still in the pipeline already owns a queue slot.
  assign in_ready = !busy && ((qtar_pkg::CREDIT_W'(count) + qtar_pkg::CREDIT_W'(inflight))
                    < qtar_pkg::CREDIT_W'(qtar_pkg::FIFO_DEPTH));
  assign in_accept = in_valid && in_ready;

  assign out_valid = (count != '0);
  assign out_pop = out_valid && out_ready;
  assign result_value = f_val[rptr];
  assign out_index = f_idx[rptr];
  assign saturated = f_sat[rptr];
  assign last_result = f_last[rptr];

  always_ff @(posedge clk) begin
    if (e_vld) begin
      f_val[wptr] <= e_res;
      f_idx[wptr] <= e_addr;
      f_sat[wptr] <= e_sat;
      f_last[wptr] <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (e_vld) wptr <= wptr + qtar_pkg::FIFO_PW'(1);
      if (out_pop) rptr <= rptr + qtar_pkg::FIFO_PW'(1);
      count <= count + qtar_pkg::FIFO_CW'(e_vld) - qtar_pkg::FIFO_CW'(out_pop);
    end
  end

  // ---------------------------------------------------------------- assertions
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    (qtar_pkg::CREDIT_W'(count) + qtar_pkg::CREDIT_W'(inflight))
      <= qtar_pkg::CREDIT_W'(qtar_pkg::FIFO_DEPTH))
    else $error("result queue overcommitted");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, term[0]} < (AW+1)'(ACC_DEPTH)) && ({1'b0, term[1]} < (AW+1)'(ACC_DEPTH)) &&
    ({1'b0, term[2]} < (AW+1)'(ACC_DEPTH)) && ({1'b0, term[3]} < (AW+1)'(ACC_DEPTH)))
    else $error("axis offset not reduced modulo the accumulator depth");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> ((result_value == 8'd0) || (result_value == 8'd255)))
    else $error("saturated result is not at a rail");

endmodule

// ===== tb/quantized_tensor_axis_reduce_tb.sv =====
// Self-checking testbench for the quantized tensor axis reduction block.
module quantized_tensor_axis_reduce_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM = 4096;
  localparam int ACC_DEPTH = 4096;
  localparam int FRAC_BITS = 24;
  localparam int IDX_W = $clog2(ACC_DEPTH);
  localparam int COORD_W = 12;
  localparam int RANDOM_ELEMENTS = 600;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef logic [3:0][COORD_W-1:0] position_t;

  typedef struct packed {
    logic [qtar_pkg::BYTE_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic sat;
    logic last;
  } reduced_out_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_BUSY, SINK_HALF, SINK_SLOW} sink_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [qtar_pkg::BYTE_W-1:0] element_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [qtar_pkg::BYTE_W-1:0] result_value;
  logic [IDX_W-1:0] out_index;
  logic saturated;
  logic last_result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [qtar_pkg::PADDR_W-1:0] paddr = '0;
  logic [qtar_pkg::PDATA_W-1:0] pwdata = '0;
  logic [qtar_pkg::PDATA_W-1:0] prdata;
  logic pready;

  // Shadow copy of the register file and of the stream position.
  logic [3:0][qtar_pkg::DIM_CFG_W-1:0] dim_cfg = {4{13'd1}};
  logic [qtar_pkg::MASK_W-1:0] mask_cfg = 4'hF;
  logic [qtar_pkg::BYTE_W-1:0] zin_cfg = '0;
  logic [qtar_pkg::BYTE_W-1:0] zout_cfg = '0;
  logic [qtar_pkg::MULT_W-1:0] mult_cfg = 32'h0100_0000;
  position_t stream_pos = '0;
  logic [qtar_pkg::ACC_W-1:0] acc_bank [ACC_DEPTH];

  logic [qtar_pkg::BYTE_W-1:0] element_queue [$];
  reduced_out_t pending_outputs [$];
  int elements_queued = 0;
  int elements_accepted = 0;
  int error_count = 0;
  int unsigned cycle_count = 0;

  int gap_left = 0;
  int burst_left = 1;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int mode_left = 0;
  sink_mode_t sink_mode = SINK_OPEN;

  quantized_tensor_axis_reduce #(
    .MAX_DIM(MAX_DIM),
    .ACC_DEPTH(ACC_DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .element_value(element_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_value(result_value),
    .out_index(out_index),
    .saturated(saturated),
    .last_result(last_result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int axis_extent(int k);
    if (dim_cfg[k] == '0) return 1;
    if (dim_cfg[k] > MAX_DIM) return MAX_DIM;
    return int'(dim_cfg[k]);
  endfunction

  // Innermost axis moves first; a coordinate at or past its last value wraps.
  function automatic position_t next_position(position_t p);
    bit carry;
    carry = 1'b1;
    for (int k = 3; k >= 0; k--) begin
      if (carry) begin
        if (p[k] >= axis_extent(k) - 1) begin
          p[k] = '0;
        end else begin
          p[k] = p[k] + 1'b1;
          carry = 1'b0;
        end
      end
    end
    return p;
  endfunction

  function automatic int elements_to_tensor_end();
    position_t walk;
    int count;
    walk = stream_pos;
    count = 0;
    do begin
      walk = next_position(walk);
      count++;
    end while (walk != '0 && count < (1 << 24));
    return count;
  endfunction

  function automatic void requantize_sum(input logic [qtar_pkg::ACC_W-1:0] sum,
                                         output logic [qtar_pkg::BYTE_W-1:0] value,
                                         output logic sat);
    logic [qtar_pkg::ACC_W-1:0] mag;
    logic [79:0] scaled;
    int level;
    mag = sum[qtar_pkg::ACC_W-1] ? -sum : sum;
    scaled = ({40'b0, mag} * {48'b0, mult_cfg} + (80'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (scaled > 80'd512) scaled = 80'd512;
    level = int'(zout_cfg)
          + (sum[qtar_pkg::ACC_W-1] ? -int'(scaled[9:0]) : int'(scaled[9:0]));
    sat = (level < 0) || (level > 255);
    value = (level < 0) ? 8'd0 : (level > 255) ? 8'd255 : qtar_pkg::BYTE_W'(level);
  endfunction

  // Adds one element into its accumulator and records the result it finishes.
  function automatic void accumulate_element(logic [qtar_pkg::BYTE_W-1:0] value);
    bit first, finish, at_end, at_max;
    longint unsigned flat;
    int slot;
    logic [qtar_pkg::ACC_W-1:0] diff;
    logic [qtar_pkg::BYTE_W-1:0] level;
    logic sat;
    reduced_out_t res;
    first = 1'b1;
    finish = 1'b1;
    at_end = 1'b1;
    flat = 0;
    for (int k = 0; k < 4; k++) begin
      at_max = stream_pos[k] >= axis_extent(k) - 1;
      if (!at_max) at_end = 1'b0;
      if (mask_cfg[k]) begin
        if (stream_pos[k] != '0) first = 1'b0;
        if (!at_max) finish = 1'b0;
      end else begin
        flat = flat * axis_extent(k) + stream_pos[k];
      end
    end
    slot = int'(flat % ACC_DEPTH);
    diff = qtar_pkg::ACC_W'(value) - qtar_pkg::ACC_W'(zin_cfg);
    acc_bank[slot] = first ? diff : acc_bank[slot] + diff;
    stream_pos = next_position(stream_pos);
    if (finish) begin
      requantize_sum(acc_bank[slot], level, sat);
      res.value = level;
      res.index = IDX_W'(slot);
      res.sat = sat;
      res.last = at_end;
      pending_outputs.push_back(res);
    end
  endfunction

  function automatic logic [qtar_pkg::BYTE_W-1:0] random_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return qtar_pkg::BYTE_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  task automatic reg_write(qtar_pkg::reg_idx_t idx, logic [qtar_pkg::PDATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      qtar_pkg::REG_DIM_N: dim_cfg[0] = value[qtar_pkg::DIM_CFG_W-1:0];
      qtar_pkg::REG_DIM_H: dim_cfg[1] = value[qtar_pkg::DIM_CFG_W-1:0];
      qtar_pkg::REG_DIM_W: dim_cfg[2] = value[qtar_pkg::DIM_CFG_W-1:0];
      qtar_pkg::REG_DIM_C: dim_cfg[3] = value[qtar_pkg::DIM_CFG_W-1:0];
      qtar_pkg::REG_AXIS_MASK: mask_cfg = value[qtar_pkg::MASK_W-1:0];
      qtar_pkg::REG_ZERO_IN: zin_cfg = value[qtar_pkg::BYTE_W-1:0];
      qtar_pkg::REG_ZERO_OUT: zout_cfg = value[qtar_pkg::BYTE_W-1:0];
      qtar_pkg::REG_REQUANT_MULT: mult_cfg = value[qtar_pkg::MULT_W-1:0];
      default: ;
    endcase
  endtask

  // Unused upper bits of the size registers sometimes carry noise.
  task automatic write_geometry(int n, int h, int w, int c,
                                logic [qtar_pkg::MASK_W-1:0] mask);
    int dims [4];
    logic [qtar_pkg::PDATA_W-1:0] junk;
    dims = '{n, h, w, c};
    for (int k = 0; k < 4; k++) begin
      junk = ($urandom_range(0, 3) == 0) ? ($urandom << qtar_pkg::DIM_CFG_W) : '0;
      reg_write(qtar_pkg::reg_idx_t'(qtar_pkg::REG_DIM_N + k),
                junk | qtar_pkg::PDATA_W'(dims[k]));
    end
    reg_write(qtar_pkg::REG_AXIS_MASK, qtar_pkg::PDATA_W'(mask));
  endtask

  task automatic set_scaling(logic [qtar_pkg::BYTE_W-1:0] zin,
                             logic [qtar_pkg::BYTE_W-1:0] zout,
                             logic [qtar_pkg::MULT_W-1:0] mult);
    reg_write(qtar_pkg::REG_ZERO_IN, qtar_pkg::PDATA_W'(zin));
    reg_write(qtar_pkg::REG_ZERO_OUT, qtar_pkg::PDATA_W'(zout));
    reg_write(qtar_pkg::REG_REQUANT_MULT, mult);
  endtask

  task automatic pick_geometry(bit keep_mask);
    int extent [4];
    int volume;
    do begin
      volume = 1;
      for (int k = 0; k < 4; k++) begin
        extent[k] = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
        volume *= (extent[k] == 0) ? 1 : extent[k];
      end
    end while (volume > 96);
    write_geometry(extent[0], extent[1], extent[2], extent[3],
                   keep_mask ? mask_cfg : qtar_pkg::MASK_W'($urandom_range(0, 15)));
  endtask

  task automatic pick_scaling();
    logic [qtar_pkg::MULT_W-1:0] mult;
    int reduced;
    reduced = 1;
    for (int k = 0; k < 4; k++) begin
      if (mask_cfg[k]) reduced *= axis_extent(k);
    end
    case ($urandom_range(0, 5))
      0: mult = (32'd1 << FRAC_BITS) / reduced;
      1: mult = $urandom_range(1 << 22, 1 << 26) / reduced;
      2: mult = $urandom;
      3: mult = '1;
      4: mult = '0;
      default: mult = 32'd1 << FRAC_BITS;
    endcase
    set_scaling(random_byte(), random_byte(), mult);
  endtask

  task automatic queue_value(logic [qtar_pkg::BYTE_W-1:0] value);
    element_queue.push_back(value);
    elements_queued++;
  endtask

  // Items that finish no accumulator give no sign of completion, hence the settling time.
  task automatic wait_idle();
    while (elements_accepted != elements_queued || pending_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic stream_elements(int count);
    repeat (count) queue_value(random_byte());
    wait_idle();
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accumulate_element(element_value);
        elements_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (element_queue.size() > 0) begin
          in_valid <= 1'b1;
          element_value <= element_queue.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready pattern changes in stretches; a requested hold blocks it entirely.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_done < hold_requests) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 160);
        sink_mode = sink_mode_t'($urandom_range(0, 3));
      end else begin
        mode_left--;
      end
      case (sink_mode)
        SINK_OPEN: out_ready <= 1'b1;
        SINK_BUSY: out_ready <= ($urandom_range(0, 9) != 0);
        SINK_HALF: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk) begin
    reduced_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("result transfer with none pending, index %0d", out_index));
      end else begin
        want = pending_outputs.pop_front();
        if (result_value !== want.value)
          report_mismatch($sformatf("index %0d value %0d, expected %0d",
                                    want.index, result_value, want.value));
        if (out_index !== want.index)
          report_mismatch($sformatf("out_index %0d, expected %0d", out_index, want.index));
        if (saturated !== want.sat)
          report_mismatch($sformatf("index %0d saturated %b, expected %b",
                                    want.index, saturated, want.sat));
        if (last_result !== want.last)
          report_mismatch($sformatf("index %0d last_result %b, expected %b",
                                    want.index, last_result, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_outputs.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int total;
    int part;
    int random_elements;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: every element is a whole tensor on its own.
    queue_value(8'h00);
    queue_value(8'hFF);
    queue_value(8'h5A);
    wait_idle();

    // No axis reduced, input zero point at the top of its range.
    write_geometry(1, 1, 2, 3, 4'b0000);
    set_scaling(8'd255, 8'd0, 32'h0100_0000);
    queue_value(8'd0);
    queue_value(8'd255);
    queue_value(8'd17);
    queue_value(8'd254);
    queue_value(8'd1);
    queue_value(8'd128);
    wait_idle();

    // Half scale rounds away from zero; the channel size shrinks mid-tensor.
    write_geometry(1, 1, 2, 5, 4'b0000);
    set_scaling(8'd10, 8'd128, 32'h0080_0000);
    stream_elements(4);
    reg_write(qtar_pkg::REG_DIM_C, 32'd2);
    stream_elements(elements_to_tensor_end());

    // Saturation at both ends, then a zero multiplier.
    write_geometry(1, 1, 1, 2, 4'b1000);
    set_scaling(8'd0, 8'd0, '1);
    queue_value(8'd200);
    queue_value(8'd100);
    wait_idle();
    set_scaling(8'd255, 8'd255, '1);
    queue_value(8'd0);
    queue_value(8'd0);
    wait_idle();
    set_scaling(8'd3, 8'd77, '0);
    queue_value(8'd9);
    queue_value(8'd250);
    wait_idle();

    // Zero sizes behave as one.
    write_geometry(0, 0, 0, 3, 4'b1110);
    set_scaling(8'd100, 8'd20, 32'h0100_0000);
    stream_elements(3);

    // Receiver holds off while a dense stream keeps arriving.
    write_geometry(1, 2, 4, 8, 4'b0000);
    set_scaling(random_byte(), random_byte(), 32'h0100_0000);
    hold_requests++;
    stream_elements(64);

    // Oversized channel size clamps to the largest size, which shows in the width stride.
    write_geometry(1, 1, 2, 2, 4'b0000);
    set_scaling(random_byte(), 8'd128, 32'h0100_0000);
    stream_elements(2);
    write_geometry(1, 1, 2, 8191, 4'b0000);
    stream_elements(12);
    write_geometry(1, 1, 2, 2, 4'b0000);
    stream_elements(elements_to_tensor_end());

    // Mean over the channel axis.
    write_geometry(1, 1, 1, 40, 4'b1000);
    set_scaling(random_byte(), 8'd128, (32'd1 << FRAC_BITS) / 32'd40);
    stream_elements(40);

    // An outer stride past the accumulator depth wraps onto entries already used.
    write_geometry(4, 1, 2, 2, 4'b1000);
    set_scaling(8'd128, 8'd128, 32'h0080_0000);
    stream_elements(4);
    write_geometry(4, 2, 2049, 2, 4'b1000);
    stream_elements(8);
    write_geometry(4, 1, 2, 2, 4'b1000);
    stream_elements(elements_to_tensor_end());

    random_elements = 0;
    while (random_elements < RANDOM_ELEMENTS) begin
      if (random_elements == 0 || $urandom_range(0, 3) != 0) pick_geometry(1'b0);
      pick_scaling();
      total = $urandom_range(1, 3) * elements_to_tensor_end();
      if (total > 1 && $urandom_range(0, 2) == 0) begin
        // Stop inside the stream and rewrite registers that are safe to change there.
        part = $urandom_range(1, total - 1);
        stream_elements(part);
        random_elements += part;
        if (mask_cfg == '0 && $urandom_range(0, 1) == 1) begin
          pick_geometry(1'b1);
        end else begin
          pick_scaling();
        end
        total = elements_to_tensor_end();
      end
      stream_elements(total);
      random_elements += total;
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/qtar_pkg.sv
rtl/core/quantized_tensor_axis_reduce.sv
tb/quantized_tensor_axis_reduce_tb.sv
